// ----- sv/tbtd_pkg.sv -----
// ----------------------------------------------------------------------------
// tbtd_pkg
// Shared types, field widths and condition test for the Thumb branch target
// decoder.
// ----------------------------------------------------------------------------
package tbtd_pkg;

  // Field widths and packed bus widths
  localparam int unsigned OpW    = 16;
  localparam int unsigned AddrW  = 32;
  localparam int unsigned FlagW  = 4;
  localparam int unsigned InW    = OpW + 5 * AddrW + FlagW;
  localparam int unsigned InBusW = ((InW + 7) / 8) * 8;
  localparam int unsigned OutW   = 1 + AddrW + 1 + AddrW;
  localparam int unsigned OutBusW = ((OutW + 7) / 8) * 8;
  // Largest POP slot offset is four times eight low registers
  localparam int unsigned SlotOfsW = 6;

  // Instruction classes that write PC
  typedef enum logic [3:0] {
    KIND_NONE,
    KIND_BCOND,
    KIND_B,
    KIND_BL,
    KIND_BLX1,
    KIND_BX,
    KIND_POP,
    KIND_MOV,
    KIND_ADD
  } kind_e;

  // Low-bit clearing applied to the target after the add
  typedef enum logic [1:0] {
    MASK_NONE,
    MASK_HALF,
    MASK_WORD
  } mask_e;

  // ARM condition codes
  typedef enum logic [3:0] {
    COND_EQ, COND_NE, COND_CS, COND_CC,
    COND_MI, COND_PL, COND_VS, COND_VC,
    COND_HI, COND_LS, COND_GE, COND_LT,
    COND_GT, COND_LE, COND_AL, COND_NV
  } cond_e;

  // Decoded request handed from the decode stage into the pipeline
  typedef struct packed {
    logic                taken;
    logic                thumb;
    mask_e               mask;
    logic                is_pop;
    logic [AddrW-1:0]    opnd_a;
    logic [AddrW-1:0]    opnd_b;
    logic [AddrW-1:0]    sp;
    logic [SlotOfsW-1:0] slot_ofs;
  } dec_t;

  // Standard condition test over N Z C V (bit 3 is N)
  function automatic logic cond_passes(cond_e cond, logic [FlagW-1:0] flags);
    logic n, z, c, v, res;
    n = flags[3];
    z = flags[2];
    c = flags[1];
    v = flags[0];
    case (cond)
      COND_EQ: res = z;
      COND_NE: res = !z;
      COND_CS: res = c;
      COND_CC: res = !c;
      COND_MI: res = n;
      COND_PL: res = !n;
      COND_VS: res = v;
      COND_VC: res = !v;
      COND_HI: res = c && !z;
      COND_LS: res = !c || z;
      COND_GE: res = (n == v);
      COND_LT: res = (n != v);
      COND_GT: res = !z && (n == v);
      COND_LE: res = z || (n != v);
      default: res = 1'b1;
    endcase
    return res;
  endfunction

endpackage

// ----- sv/tbtd_decode.sv -----
// ----------------------------------------------------------------------------
// tbtd_decode
// Classifies one Thumb opcode and selects the adder operands, target mask,
// resulting state bit and POP slot offset.
// ----------------------------------------------------------------------------
module tbtd_decode (
  input  logic [tbtd_pkg::OpW-1:0]   opcode_i,
  input  logic [tbtd_pkg::AddrW-1:0] pc_value_i,
  input  logic [tbtd_pkg::AddrW-1:0] lr_value_i,
  input  logic [tbtd_pkg::AddrW-1:0] sp_value_i,
  input  logic [tbtd_pkg::AddrW-1:0] rm_value_i,
  input  logic [tbtd_pkg::AddrW-1:0] stack_word_i,
  input  logic [tbtd_pkg::FlagW-1:0] cond_flags_i,
  output tbtd_pkg::dec_t             dec_o
);
  import tbtd_pkg::*;

  kind_e                kind;
  logic [AddrW-1:0]     off8_sx;
  logic [AddrW-1:0]     off11_sx;
  logic [AddrW-1:0]     off11_zx;
  logic [3:0]           reg_cnt;

  // Classify the opcode; the patterns do not overlap
  always_comb begin
    unique casez (opcode_i)
      16'b1101_????_????_????: kind = (opcode_i[11:8] != 4'hf) ? KIND_BCOND : KIND_NONE;
      16'b1110_0???_????_????: kind = KIND_B;
      16'b1111_1???_????_????: kind = KIND_BL;
      16'b1110_1???_????_????: kind = KIND_BLX1;
      16'b0100_0111_????_?000: kind = KIND_BX;
      16'b1011_1101_????_????: kind = KIND_POP;
      16'b0100_0110_1???_?111: kind = KIND_MOV;
      16'b0100_0100_1???_?111: kind = KIND_ADD;
      default:                 kind = KIND_NONE;
    endcase
  end

  // Branch offsets, already doubled
  assign off8_sx  = {{(AddrW-9){opcode_i[7]}}, opcode_i[7:0], 1'b0};
  assign off11_sx = {{(AddrW-12){opcode_i[10]}}, opcode_i[10:0], 1'b0};
  assign off11_zx = {{(AddrW-12){1'b0}}, opcode_i[10:0], 1'b0};

  // Count listed low registers of a POP
  always_comb begin
    reg_cnt = '0;
    for (int i = 0; i < 8; i++) begin
      reg_cnt = reg_cnt + {3'b000, opcode_i[i]};
    end
  end

  // Select operands per class; a request that is not taken adds zero to zero
  always_comb begin
    dec_o          = '0;
    dec_o.thumb    = 1'b1;
    dec_o.mask     = MASK_NONE;
    dec_o.sp       = sp_value_i;
    dec_o.slot_ofs = {reg_cnt, 2'b00};
    case (kind)
      KIND_BCOND: begin
        if (cond_passes(cond_e'(opcode_i[11:8]), cond_flags_i)) begin
          dec_o.taken  = 1'b1;
          dec_o.opnd_a = pc_value_i;
          dec_o.opnd_b = off8_sx;
        end
      end
      KIND_B: begin
        dec_o.taken  = 1'b1;
        dec_o.opnd_a = pc_value_i;
        dec_o.opnd_b = off11_sx;
      end
      KIND_BL: begin
        dec_o.taken  = 1'b1;
        dec_o.opnd_a = lr_value_i;
        dec_o.opnd_b = off11_zx;
      end
      KIND_BLX1: begin
        dec_o.taken  = 1'b1;
        dec_o.thumb  = 1'b0;
        dec_o.mask   = MASK_WORD;
        dec_o.opnd_a = lr_value_i;
        dec_o.opnd_b = off11_zx;
      end
      KIND_BX: begin
        dec_o.taken  = 1'b1;
        dec_o.thumb  = rm_value_i[0];
        dec_o.mask   = MASK_HALF;
        dec_o.opnd_a = rm_value_i;
      end
      KIND_POP: begin
        dec_o.taken  = 1'b1;
        dec_o.is_pop = 1'b1;
        dec_o.thumb  = stack_word_i[0];
        dec_o.mask   = MASK_HALF;
        dec_o.opnd_a = stack_word_i;
      end
      KIND_MOV: begin
        dec_o.taken  = 1'b1;
        dec_o.opnd_a = rm_value_i;
      end
      KIND_ADD: begin
        dec_o.taken  = 1'b1;
        dec_o.opnd_a = pc_value_i;
        dec_o.opnd_b = rm_value_i;
      end
      default: begin
        dec_o.taken = 1'b0;
      end
    endcase
  end

endmodule

// ----- sv/thumb_branch_target_decode.sv -----
// ----------------------------------------------------------------------------
// thumb_branch_target_decode
// Three-stage pipeline that predicts the PC target of one Thumb opcode.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis carries one request per opcode: the opcode, PC, LR,
//   SP, the Rm register value, the stack word a POP would load into PC, and
//   the NZCV flags. Master stream m_axis returns one result per request in
//   order: taken bit, target address, Thumb bit after the instruction and
//   the POP slot address.
//   An accepted request is registered in stage 1, then stage 2, then the
//   stage 3 output register, which drives m_axis tvalid.
//   The stages are decode and operand select, the 32-bit target and slot
//   adds, then masking and the output register. Throughput is one request
//   per cycle unless m_axis stalls; the adder stage sets the clock period.
//   Each stage carries its own valid bit and advances when the stage after
//   it is empty or moving, so bubbles close up while m_axis stalls. When the
//   receiver holds tready low with all stages full, s_axis tready drops and
//   the held result stays unchanged.
//   Reset clears all valid bits; the block then accepts at once.
// ----------------------------------------------------------------------------
module thumb_branch_target_decode (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // opcode[15:0], pc_value[47:16], lr_value[79:48], sp_value[111:80],
  // rm_value[143:112], stack_word[175:144], cond_flags[179:176], zero pad
  input  logic [tbtd_pkg::InBusW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // branch_taken[0], dest_address[32:1], thumb_after[33],
  // stack_slot_address[65:34], zero pad
  output logic [tbtd_pkg::OutBusW-1:0]  m_axis_tdata
);
  import tbtd_pkg::*;

  dec_t dec;

  // Stage 1: decoded request
  logic v1_q;
  dec_t s1_q;

  // Stage 2: sums
  logic             v2_q;
  logic             s2_taken_q, s2_thumb_q;
  mask_e            s2_mask_q;
  logic [AddrW-1:0] s2_sum_q, s2_slot_q;

  // Stage 3: output register
  logic             v3_q;
  logic             s3_taken_q, s3_thumb_q;
  logic [AddrW-1:0] s3_dest_q, s3_slot_q;

  logic             rdy1, rdy2, rdy3;
  logic [AddrW-1:0] dest_masked;

  tbtd_decode u_decode (
    .opcode_i     (s_axis_tdata[15:0]),
    .pc_value_i   (s_axis_tdata[47:16]),
    .lr_value_i   (s_axis_tdata[79:48]),
    .sp_value_i   (s_axis_tdata[111:80]),
    .rm_value_i   (s_axis_tdata[143:112]),
    .stack_word_i (s_axis_tdata[175:144]),
    .cond_flags_i (s_axis_tdata[179:176]),
    .dec_o        (dec)
  );

  // Stall chain: a stage advances when it is empty or its successor moves
  assign rdy3          = !v3_q || m_axis_tready;
  assign rdy2          = !v2_q || rdy3;
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // Stage 1: hold the decoded request
  always_ff @(posedge clk_i) begin
    if (rdy1 && s_axis_tvalid) begin
      s1_q <= dec;
    end
  end

  // Stage 2: add target operands and compute the POP slot address
  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      s2_taken_q <= s1_q.taken;
      s2_thumb_q <= s1_q.thumb;
      s2_mask_q  <= s1_q.mask;
      s2_sum_q   <= s1_q.opnd_a + s1_q.opnd_b;
      s2_slot_q  <= s1_q.is_pop ? (s1_q.sp + {{(AddrW-SlotOfsW){1'b0}}, s1_q.slot_ofs})
                                : '0;
    end
  end

  // Clear low target bits as the instruction class asks
  always_comb begin
    case (s2_mask_q)
      MASK_HALF: dest_masked = {s2_sum_q[AddrW-1:1], 1'b0};
      MASK_WORD: dest_masked = {s2_sum_q[AddrW-1:2], 2'b00};
      default:   dest_masked = s2_sum_q;
    endcase
  end

  // Stage 3: output register
  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      s3_taken_q <= s2_taken_q;
      s3_thumb_q <= s2_thumb_q;
      s3_dest_q  <= dest_masked;
      s3_slot_q  <= s2_slot_q;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {{(OutBusW-OutW){1'b0}}, s3_slot_q, s3_thumb_q, s3_dest_q,
                          s3_taken_q};

  // A result that does not branch reports a zero target and Thumb state
  a_not_taken_dest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !s3_taken_q) |-> (s3_dest_q == '0 && s3_thumb_q))
    else $error("not-taken result with nonzero target or ARM state");

  // Only a POP, which is always taken, reports a slot address
  a_slot_only_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !s3_taken_q) |-> (s3_slot_q == '0))
    else $error("slot address on a result that does not branch");

  // Back-pressure reaches the input only when all stages are full and m_axis stalls
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (v1_q && v2_q && v3_q && !m_axis_tready))
    else $error("input stalled while a pipeline stage is free");

endmodule
